// ===== rtl/rgma_pkg.sv =====
// Shared types, codes and default constants of the room group mutex arbiter.
package rgma_pkg;

  localparam int unsigned MaxRoomsDef    = 16;
  localparam int unsigned TicketWidthDef = 16;
  localparam int unsigned RoomW          = 4;
  localparam int unsigned FieldW         = 16;
  localparam int unsigned CfgW           = 5;
  localparam logic [CfgW-1:0] RoomsInUseRst = 5'd16;

  typedef enum logic [1:0] {
    OP_ENTER  = 2'd0,
    OP_EXIT   = 2'd1,
    OP_CHANGE = 2'd2,
    OP_NOP    = 2'd3
  } rgma_op_e;

  // Command broadcast to every counter cell of the chain.
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_ARRIVE = 3'd1,
    CMD_OPEN   = 3'd2,
    CMD_DEPART = 3'd3,
    CMD_LOAD   = 3'd4,
    CMD_SCAN   = 3'd5
  } rgma_cmd_e;

  typedef struct packed {
    rgma_cmd_e cmd;
    logic      sel;
  } rgma_cell_ctrl_t;

  typedef struct packed {
    rgma_op_e         opcode;
    logic [RoomW-1:0] room;
  } rgma_req_t;

  typedef struct packed {
    logic              caller_admitted;
    logic [FieldW-1:0] caller_ticket;
    logic              last_leaver;
    logic              active_valid;
    logic [RoomW-1:0]  active_room;
    logic [FieldW-1:0] released_count;
    logic              error;
  } rgma_rsp_t;

endpackage

// ===== rtl/rgma_cell.sv =====
// One room cell: ticket counters of a room and one stage of the scan token ring.
module rgma_cell #(
  parameter int unsigned TicketWidth = rgma_pkg::TicketWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rgma_pkg::rgma_cell_ctrl_t   ctrl_i,
  input  logic                        tok_i,
  output logic                        tok_o,
  output logic                        hit_o,
  output logic [TicketWidth-1:0]      ticket_o,
  output logic [TicketWidth-1:0]      adm_o,
  output logic [TicketWidth-1:0]      wait_o,
  output logic                        last_o
);

  logic [TicketWidth-1:0] arr_q, arr_d, adm_q, adm_d, dep_q, dep_d;
  logic                   tok_q, tok_d;
  logic [TicketWidth-1:0] arr_inc, dep_inc, diff;
  logic                   waiting, hit;

  assign arr_inc = arr_q + TicketWidth'(1);
  assign dep_inc = dep_q + TicketWidth'(1);
  assign diff    = arr_q - adm_q;
  // A room has waiters when arrivals lead admitted by less than half the ticket range.
  assign waiting = (diff != '0) && !diff[TicketWidth-1];
  assign hit     = (ctrl_i.cmd == rgma_pkg::CMD_SCAN) && tok_q && waiting;

  always_comb begin
    arr_d = arr_q;
    adm_d = adm_q;
    dep_d = dep_q;
    tok_d = tok_q;
    case (ctrl_i.cmd)
      rgma_pkg::CMD_ARRIVE: begin
        if (ctrl_i.sel) arr_d = arr_inc;
      end
      rgma_pkg::CMD_OPEN: begin
        if (ctrl_i.sel) adm_d = arr_q;
      end
      rgma_pkg::CMD_DEPART: begin
        if (ctrl_i.sel) dep_d = dep_inc;
      end
      rgma_pkg::CMD_LOAD: begin
        tok_d = ctrl_i.sel;
      end
      rgma_pkg::CMD_SCAN: begin
        tok_d = tok_i;
        if (hit) adm_d = arr_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_q <= '0;
      adm_q <= '0;
      dep_q <= '0;
      tok_q <= 1'b0;
    end else begin
      arr_q <= arr_d;
      adm_q <= adm_d;
      dep_q <= dep_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o    = tok_q;
  assign hit_o    = hit;
  assign ticket_o = ctrl_i.sel ? arr_inc : '0;
  assign adm_o    = ctrl_i.sel ? adm_q : '0;
  assign wait_o   = ((ctrl_i.sel || hit) && waiting) ? diff : '0;
  assign last_o   = ctrl_i.sel && (dep_inc == adm_q);

endmodule

// ===== rtl/rgma_chain.sv =====
// Row of room cells with the token ring links and the wired-OR read-back.
module rgma_chain #(
  parameter int unsigned MaxRooms    = rgma_pkg::MaxRoomsDef,
  parameter int unsigned TicketWidth = rgma_pkg::TicketWidthDef,
  localparam int unsigned RoomIdxW   = (MaxRooms > 1) ? $clog2(MaxRooms) : 1,
  localparam int unsigned CountW     = $clog2(MaxRooms + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rgma_pkg::rgma_cmd_e     cmd_i,
  input  logic [RoomIdxW-1:0]     sel_idx_i,
  input  logic [CountW-1:0]       n_i,
  output logic [TicketWidth-1:0]  ticket_o,
  output logic [TicketWidth-1:0]  adm_o,
  output logic [TicketWidth-1:0]  wait_o,
  output logic                    last_o,
  output logic                    hit_o,
  output logic [RoomIdxW-1:0]     hit_idx_o
);

  logic [MaxRooms-1:0]    tok, tok_in, hit, last;
  logic [TicketWidth-1:0] ticket [MaxRooms];
  logic [TicketWidth-1:0] adm    [MaxRooms];
  logic [TicketWidth-1:0] waitv  [MaxRooms];
  logic                   tok_wrap;
  logic [CountW-1:0]      n_m1;

  assign n_m1 = n_i - CountW'(1);

  // The token leaves the last room in use and comes back to room zero.
  always_comb begin
    tok_wrap = 1'b0;
    for (int j = 0; j < MaxRooms; j++) begin
      if (CountW'(j) == n_m1) tok_wrap = tok_wrap | tok[j];
    end
  end

  for (genvar g = 0; g < MaxRooms; g++) begin : g_cell
    rgma_pkg::rgma_cell_ctrl_t ctrl;

    assign ctrl.cmd = cmd_i;
    assign ctrl.sel = (cmd_i != rgma_pkg::CMD_SCAN) && (sel_idx_i == RoomIdxW'(g));

    if (g == 0) begin : g_head
      assign tok_in[g] = tok_wrap;
    end else begin : g_body
      assign tok_in[g] = tok[g-1] && (CountW'(g) < n_i);
    end

    rgma_cell #(
      .TicketWidth(TicketWidth)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .tok_i   (tok_in[g]),
      .tok_o   (tok[g]),
      .hit_o   (hit[g]),
      .ticket_o(ticket[g]),
      .adm_o   (adm[g]),
      .wait_o  (waitv[g]),
      .last_o  (last[g])
    );
  end

  // At most one cell drives nonzero data at a time, so the read-back is an OR.
  always_comb begin
    ticket_o  = '0;
    adm_o     = '0;
    wait_o    = '0;
    hit_idx_o = '0;
    for (int i = 0; i < MaxRooms; i++) begin
      ticket_o = ticket_o | ticket[i];
      adm_o    = adm_o | adm[i];
      wait_o   = wait_o | waitv[i];
      if (hit[i]) hit_idx_o = hit_idx_o | RoomIdxW'(i);
    end
  end

  assign last_o = |last;
  assign hit_o  = |hit;

endmodule

// ===== rtl/room_group_mutex_arbiter_core.sv =====
// Top level of the room group mutex arbiter: command sequencer over the room cell chain.
//
// Group mutual exclusion arbiter. One room at a time is open; each room keeps
// wrapping arrival, admitted and departure tickets in its own cell of a chain.
// A command beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on rsp_o for the single cycle in which done_o is
// high, and the receiver must take it then because it cannot hold results off.
// The block works on one command at a time. A no-op or an exit with no open
// room goes straight to the result, an exit that does not close the batch
// takes a departure step and the result, and an enter takes a ticket update,
// an optional room opening and the result. An exit that closes the batch takes
// the departure step, the token planting, the round-robin search and the
// result step; a change with a room open adds its ticket step in front. A
// token walks the cell chain one room per cycle, so the search covers up to n
// rooms for n rooms in use. Planting the token first takes n away from the
// open room index plus one as long as that is not below n, which happens for
// the last room in use as well as for a room outside the rooms in use. Busy
// drops for one cycle between commands. rooms_in_use is written through
// cfg_we_i and cfg_wdata_i; zero acts as one room and values above MaxRooms
// act as MaxRooms. Room numbers on the input are taken modulo MaxRooms.
module room_group_mutex_arbiter_core #(
  parameter int unsigned MaxRooms    = rgma_pkg::MaxRoomsDef,
  parameter int unsigned TicketWidth = rgma_pkg::TicketWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rgma_pkg::rgma_req_t             req_i,
  output logic                            done_o,
  output rgma_pkg::rgma_rsp_t             rsp_o,
  input  logic                            cfg_we_i,
  input  logic [rgma_pkg::CfgW-1:0]       cfg_wdata_i
);

  localparam int unsigned RoomIdxW = (MaxRooms > 1) ? $clog2(MaxRooms) : 1;
  localparam int unsigned CountW   = $clog2(MaxRooms + 1);
  localparam int unsigned CmpW     = (CountW > rgma_pkg::CfgW) ? CountW : rgma_pkg::CfgW;
  localparam int unsigned RoomCodes = 2 ** rgma_pkg::RoomW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ENTER  = 7'b0000010,
    S_OPEN   = 7'b0000100,
    S_DEPART = 7'b0001000,
    S_REDUCE = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  logic                        open_valid_q, open_valid_d;
  logic [RoomIdxW-1:0]         open_room_q, open_room_d;
  logic [rgma_pkg::CfgW-1:0]   rooms_in_use_q;

  rgma_pkg::rgma_op_e          op_q, op_d;
  logic [RoomIdxW-1:0]         room_q, room_d;
  logic [TicketWidth-1:0]      ticket_q, ticket_d;
  logic [TicketWidth-1:0]      rel_q, rel_d;
  logic                        ahead_q, ahead_d;
  logic                        opened_q, opened_d;
  logic                        last_q, last_d;
  logic                        err_q, err_d;
  logic [CountW-1:0]           pos_q, pos_d;
  logic [RoomIdxW-1:0]         k_q, k_d;

  rgma_pkg::rgma_cmd_e         cmd;
  logic [RoomIdxW-1:0]         sel_idx;
  logic [CountW-1:0]           n_c;
  logic [CmpW-1:0]             cfg_ext;
  logic [TicketWidth-1:0]      ticket_c, adm_c, wait_c, diff_c;
  logic                        ahead_c, last_c, hit_c;
  logic [RoomIdxW-1:0]         hit_idx_c;
  logic [RoomIdxW-1:0]         room_mod_tbl [RoomCodes];

  // Input room numbers folded into the rooms that exist.
  for (genvar g = 0; g < RoomCodes; g++) begin : g_room_mod
    assign room_mod_tbl[g] = RoomIdxW'(g % MaxRooms);
  end

  // Effective number of rooms in the round-robin, clamped to one..MaxRooms.
  assign cfg_ext = CmpW'(rooms_in_use_q);
  always_comb begin
    if (rooms_in_use_q == '0) begin
      n_c = CountW'(1);
    end else if (cfg_ext > CmpW'(MaxRooms)) begin
      n_c = CountW'(MaxRooms);
    end else begin
      n_c = CountW'(rooms_in_use_q);
    end
  end

  rgma_chain #(
    .MaxRooms   (MaxRooms),
    .TicketWidth(TicketWidth)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sel_idx_i(sel_idx),
    .n_i      (n_c),
    .ticket_o (ticket_c),
    .adm_o    (adm_c),
    .wait_o   (wait_c),
    .last_o   (last_c),
    .hit_o    (hit_c),
    .hit_idx_o(hit_idx_c)
  );

  // The new ticket is ahead of admitted when the caller has to queue.
  assign diff_c  = ticket_c - adm_c;
  assign ahead_c = (diff_c != '0) && !diff_c[TicketWidth-1];

  always_comb begin
    state_d      = state_q;
    open_valid_d = open_valid_q;
    open_room_d  = open_room_q;
    op_d         = op_q;
    room_d       = room_q;
    ticket_d     = ticket_q;
    rel_d        = rel_q;
    ahead_d      = ahead_q;
    opened_d     = opened_q;
    last_d       = last_q;
    err_d        = err_q;
    pos_d        = pos_q;
    k_d          = k_q;
    cmd          = rgma_pkg::CMD_NONE;
    sel_idx      = room_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = req_i.opcode;
          room_d   = room_mod_tbl[req_i.room];
          ticket_d = '0;
          rel_d    = '0;
          ahead_d  = 1'b0;
          opened_d = 1'b0;
          last_d   = 1'b0;
          err_d    = 1'b0;
          unique case (req_i.opcode) inside
            rgma_pkg::OP_ENTER, rgma_pkg::OP_CHANGE: begin
              state_d = S_ENTER;
            end
            rgma_pkg::OP_EXIT: begin
              if (open_valid_q) begin
                state_d = S_DEPART;
              end else begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ENTER: begin
        cmd      = rgma_pkg::CMD_ARRIVE;
        ticket_d = ticket_c;
        ahead_d  = ahead_c;
        if (op_q == rgma_pkg::OP_CHANGE && open_valid_q) begin
          state_d = S_DEPART;
        end else begin
          if (op_q == rgma_pkg::OP_CHANGE) err_d = 1'b1;
          state_d = (ahead_c && !open_valid_q) ? S_OPEN : S_DONE;
        end
      end
      S_OPEN: begin
        cmd          = rgma_pkg::CMD_OPEN;
        rel_d        = wait_c;
        open_valid_d = 1'b1;
        open_room_d  = room_q;
        opened_d     = 1'b1;
        state_d      = S_DONE;
      end
      S_DEPART: begin
        cmd     = rgma_pkg::CMD_DEPART;
        sel_idx = open_room_q;
        if (last_c) begin
          last_d       = 1'b1;
          open_valid_d = 1'b0;
          open_room_d  = '0;
          pos_d        = CountW'(open_room_q) + CountW'(1);
          state_d      = S_REDUCE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REDUCE: begin
        // Bring the scan start below the rooms in use, then plant the token there.
        sel_idx = pos_q[RoomIdxW-1:0];
        if (pos_q >= n_c) begin
          pos_d = pos_q - n_c;
        end else begin
          cmd     = rgma_pkg::CMD_LOAD;
          k_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = rgma_pkg::CMD_SCAN;
        if (hit_c) begin
          open_valid_d = 1'b1;
          open_room_d  = hit_idx_c;
          rel_d        = wait_c;
          opened_d     = (hit_idx_c == room_q);
          state_d      = S_DONE;
        end else if (k_q == RoomIdxW'(n_c - CountW'(1))) begin
          if (op_q == rgma_pkg::OP_CHANGE) err_d = 1'b1;
          state_d = S_DONE;
        end else begin
          k_d = k_q + RoomIdxW'(1);
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      open_valid_q   <= 1'b0;
      open_room_q    <= '0;
      rooms_in_use_q <= rgma_pkg::RoomsInUseRst;
    end else begin
      state_q      <= state_d;
      open_valid_q <= open_valid_d;
      open_room_q  <= open_room_d;
      if (cfg_we_i) rooms_in_use_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    room_q   <= room_d;
    ticket_q <= ticket_d;
    rel_q    <= rel_d;
    ahead_q  <= ahead_d;
    opened_q <= opened_d;
    last_q   <= last_d;
    err_q    <= err_d;
    pos_q    <= pos_d;
    k_q      <= k_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // The caller is admitted unless its ticket still queues behind admitted.
  assign rsp_o.caller_admitted = (op_q == rgma_pkg::OP_ENTER || op_q == rgma_pkg::OP_CHANGE)
                                 && (!ahead_q || opened_q);
  assign rsp_o.caller_ticket   = rgma_pkg::FieldW'(ticket_q);
  assign rsp_o.last_leaver     = last_q;
  assign rsp_o.active_valid    = open_valid_q;
  assign rsp_o.active_room     = open_valid_q ? rgma_pkg::RoomW'(open_room_q) : '0;
  assign rsp_o.released_count  = rgma_pkg::FieldW'(rel_q);
  assign rsp_o.error           = err_q;

endmodule

// ===== rtl/rgma_checker.sv =====
// Port-level checks of the room group mutex arbiter, bound to the top level.
module rgma_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input rgma_pkg::rgma_rsp_t  rsp_o
);

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat shown while the arbiter is idle");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command beat accepted but busy did not rise");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("arbiter stayed busy after its result beat");

  a_closed_room_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.active_valid) |-> (rsp_o.active_room == '0))
    else $error("active room reported while no room is open");

  a_release_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.released_count != '0) |-> rsp_o.active_valid)
    else $error("waiters released but no room is open");

endmodule

bind room_group_mutex_arbiter_core rgma_checker u_rgma_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
